/* rtl/core/source_text_tokenizer_top_defines.svh */
// Assertion macros shared by the tokenizer RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/stt_pkg.sv */
// Shared types and constants of the source text tokenizer.
// Used by the interfaces, the scan step, the result queue and the top level.
package stt_pkg;

	localparam int TOK_W = 16;

	// Scan modes held between bytes.
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_NUM     = 3'd2,
		MODE_SLASH   = 3'd3,
		MODE_EQ      = 3'd4,
		MODE_CMT     = 3'd5,
		MODE_CMTSTAR = 3'd6,
		MODE_HALT    = 3'd7
	} mode_t;

	// Token kind codes.
	localparam logic [4:0] K_ID     = 5'd0;
	localparam logic [4:0] K_NUM    = 5'd1;
	localparam logic [4:0] K_AUTO   = 5'd2;
	localparam logic [4:0] K_EXTRN  = 5'd3;
	localparam logic [4:0] K_IF     = 5'd4;
	localparam logic [4:0] K_WHILE  = 5'd5;
	localparam logic [4:0] K_LPAREN = 5'd6;
	localparam logic [4:0] K_RPAREN = 5'd7;
	localparam logic [4:0] K_LBRACK = 5'd8;
	localparam logic [4:0] K_RBRACK = 5'd9;
	localparam logic [4:0] K_LBRACE = 5'd10;
	localparam logic [4:0] K_RBRACE = 5'd11;
	localparam logic [4:0] K_SEMI   = 5'd12;
	localparam logic [4:0] K_COMMA  = 5'd13;
	localparam logic [4:0] K_PLUS   = 5'd14;
	localparam logic [4:0] K_MINUS  = 5'd15;
	localparam logic [4:0] K_STAR   = 5'd16;
	localparam logic [4:0] K_SLASH  = 5'd17;
	localparam logic [4:0] K_PCT    = 5'd18;
	localparam logic [4:0] K_EQUALS = 5'd19;
	localparam logic [4:0] K_ASPLUS = 5'd20;
	localparam logic [4:0] K_ASMIN  = 5'd21;
	localparam logic [4:0] K_ASMUL  = 5'd22;
	localparam logic [4:0] K_ASDIV  = 5'd23;
	localparam logic [4:0] K_ASMOD  = 5'd24;
	localparam logic [4:0] K_EOF    = 5'd25;
	localparam logic [4:0] K_ERROR  = 5'd26;

	// Keyword spellings, right aligned in the word prefix.
	localparam logic [47:0] KW_AUTO  = 48'h0000_6175_746F;
	localparam logic [47:0] KW_EXTRN = 48'h0065_7874_726E;
	localparam logic [47:0] KW_IF    = 48'h0000_0000_6966;
	localparam logic [47:0] KW_WHILE = 48'h0077_6869_6C65;

	// Characters with a role of their own.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PCT   = 8'h25;

	localparam logic [TOK_W-1:0] LEN_MAX = 16'hFFFF;

	// One result beat.
	typedef struct packed {
		logic [4:0]       kind;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] length;
		logic             last;
	} token_t;

	// Everything one byte produces: zero, one or two tokens.
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} step_res_t;

endpackage

/* rtl/core/stt_if.sv */
// Handshake interfaces for the tokenizer's text input and token output.
// Depends on stt_pkg for the field width.
interface stt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface stt_token_if;
	logic                      valid;
	logic                      ready;
	logic [4:0]                token_kind;
	logic [stt_pkg::TOK_W-1:0] token_start;
	logic [stt_pkg::TOK_W-1:0] token_length;
	logic                      last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

/* rtl/core/stt_step.sv */
// Combinational scan step: next scanner state and the tokens caused by one byte.
// Depends on stt_pkg.
module stt_step #(
	parameter int POS_WIDTH = 16
) (
	input  stt_pkg::mode_t             mode,
	input  logic [POS_WIDTH-1:0]       pos,
	input  logic [POS_WIDTH-1:0]       pstart,
	input  logic [stt_pkg::TOK_W-1:0]  plen,
	input  logic [47:0]                prefix,
	input  logic [7:0]                 text_byte,
	input  logic                       end_of_text,
	output stt_pkg::mode_t             mode_nx,
	output logic [POS_WIDTH-1:0]       pos_nx,
	output logic [POS_WIDTH-1:0]       pstart_nx,
	output logic [stt_pkg::TOK_W-1:0]  plen_nx,
	output logic [47:0]                prefix_nx,
	output stt_pkg::step_res_t         res
);

	localparam int SW = (POS_WIDTH < stt_pkg::TOK_W) ? POS_WIDTH : stt_pkg::TOK_W;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	logic [stt_pkg::TOK_W-1:0] p16;
	logic [stt_pkg::TOK_W-1:0] ps16;
	logic                      pend_vld;
	stt_pkg::token_t           pend_tok;
	logic                      st_emit;
	logic                      st_begin;
	stt_pkg::mode_t            st_mode;
	stt_pkg::token_t           st_tok;
	logic [4:0]                word_k;
	logic [4:0]                punct_k;
	logic                      punct_hit;
	logic                      a_vld;
	logic                      b_vld;
	stt_pkg::token_t           a_tok;
	stt_pkg::token_t           b_tok;
	logic [4:0]                comp_k;
	logic                      comp_hit;

	// Offsets as seen on the 16-bit token fields.
	always_comb begin
		p16 = '0;
		ps16 = '0;
		p16[SW-1:0] = pos[SW-1:0];
		ps16[SW-1:0] = pstart[SW-1:0];
	end

	// Keyword match on exact length and stored characters.
	always_comb begin
		word_k = stt_pkg::K_ID;
		if (plen == 16'd4 && prefix == stt_pkg::KW_AUTO) begin
			word_k = stt_pkg::K_AUTO;
		end else if (plen == 16'd5 && prefix == stt_pkg::KW_EXTRN) begin
			word_k = stt_pkg::K_EXTRN;
		end else if (plen == 16'd2 && prefix == stt_pkg::KW_IF) begin
			word_k = stt_pkg::K_IF;
		end else if (plen == 16'd5 && prefix == stt_pkg::KW_WHILE) begin
			word_k = stt_pkg::K_WHILE;
		end
	end

	// The token held in a pending mode, emitted when the next byte ends it.
	always_comb begin
		pend_vld = 1'b1;
		pend_tok = '0;
		pend_tok.start = ps16;
		case (mode)
			stt_pkg::MODE_WORD: begin
				pend_tok.kind = word_k;
				pend_tok.length = plen;
			end
			stt_pkg::MODE_NUM: begin
				pend_tok.kind = stt_pkg::K_NUM;
				pend_tok.length = plen;
			end
			stt_pkg::MODE_SLASH: begin
				pend_tok.kind = stt_pkg::K_SLASH;
				pend_tok.length = 16'd1;
			end
			stt_pkg::MODE_EQ: begin
				pend_tok.kind = stt_pkg::K_EQUALS;
				pend_tok.length = 16'd1;
			end
			default: begin
				pend_vld = 1'b0;
			end
		endcase
	end

	// Single-character punctuation and operators.
	always_comb begin
		punct_hit = 1'b1;
		punct_k = stt_pkg::K_ERROR;
		case (text_byte)
			8'h28: punct_k = stt_pkg::K_LPAREN;
			8'h29: punct_k = stt_pkg::K_RPAREN;
			8'h5B: punct_k = stt_pkg::K_LBRACK;
			8'h5D: punct_k = stt_pkg::K_RBRACK;
			8'h7B: punct_k = stt_pkg::K_LBRACE;
			8'h7D: punct_k = stt_pkg::K_RBRACE;
			8'h3B: punct_k = stt_pkg::K_SEMI;
			8'h2C: punct_k = stt_pkg::K_COMMA;
			stt_pkg::CH_PLUS: punct_k = stt_pkg::K_PLUS;
			stt_pkg::CH_MINUS: punct_k = stt_pkg::K_MINUS;
			stt_pkg::CH_STAR: punct_k = stt_pkg::K_STAR;
			stt_pkg::CH_PCT: punct_k = stt_pkg::K_PCT;
			default: punct_hit = 1'b0;
		endcase
	end

	// What a byte does when seen between tokens.
	always_comb begin
		st_emit = 1'b0;
		st_begin = 1'b0;
		st_mode = stt_pkg::MODE_IDLE;
		st_tok = '0;
		st_tok.start = p16;
		st_tok.length = 16'd1;
		if (text_byte == stt_pkg::CH_TAB || text_byte == stt_pkg::CH_SPACE ||
				text_byte == stt_pkg::CH_CR || text_byte == stt_pkg::CH_LF) begin
			st_mode = stt_pkg::MODE_IDLE;
		end else if (text_byte == stt_pkg::CH_SLASH) begin
			st_begin = 1'b1;
			st_mode = stt_pkg::MODE_SLASH;
		end else if (text_byte == stt_pkg::CH_EQ) begin
			st_begin = 1'b1;
			st_mode = stt_pkg::MODE_EQ;
		end else if (text_byte == stt_pkg::CH_NUL) begin
			st_emit = 1'b1;
			st_tok.kind = stt_pkg::K_EOF;
			st_tok.length = '0;
		end else if (punct_hit) begin
			st_emit = 1'b1;
			st_tok.kind = punct_k;
		end else if (is_letter(text_byte)) begin
			st_begin = 1'b1;
			st_mode = stt_pkg::MODE_WORD;
		end else if (is_digit(text_byte)) begin
			st_begin = 1'b1;
			st_mode = stt_pkg::MODE_NUM;
		end else begin
			st_emit = 1'b1;
			st_tok.kind = stt_pkg::K_ERROR;
			st_mode = stt_pkg::MODE_HALT;
		end
	end

	// Compound assignment after '='.
	always_comb begin
		comp_hit = 1'b1;
		comp_k = stt_pkg::K_ASPLUS;
		case (text_byte)
			stt_pkg::CH_PLUS: comp_k = stt_pkg::K_ASPLUS;
			stt_pkg::CH_MINUS: comp_k = stt_pkg::K_ASMIN;
			stt_pkg::CH_STAR: comp_k = stt_pkg::K_ASMUL;
			stt_pkg::CH_SLASH: comp_k = stt_pkg::K_ASDIV;
			stt_pkg::CH_PCT: comp_k = stt_pkg::K_ASMOD;
			default: comp_hit = 1'b0;
		endcase
	end

	// Main scan decision: up to two tokens, first a then b.
	always_comb begin
		logic do_start;
		logic do_extend;
		do_start = 1'b0;
		do_extend = 1'b0;
		a_vld = 1'b0;
		b_vld = 1'b0;
		a_tok = pend_tok;
		b_tok = st_tok;
		mode_nx = mode;
		pos_nx = pos;
		pstart_nx = pstart;
		plen_nx = plen;
		prefix_nx = prefix;
		if (mode == stt_pkg::MODE_HALT) begin
			mode_nx = stt_pkg::MODE_HALT;
		end else if (end_of_text) begin
			a_vld = pend_vld;
			b_vld = 1'b1;
			b_tok = '0;
			b_tok.kind = stt_pkg::K_EOF;
			b_tok.start = p16;
			mode_nx = stt_pkg::MODE_IDLE;
		end else begin
			pos_nx = pos + 1'b1;
			case (mode)
				stt_pkg::MODE_WORD: begin
					if (is_letter(text_byte) || is_digit(text_byte)) begin
						do_extend = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_NUM: begin
					if (is_digit(text_byte)) begin
						do_extend = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_SLASH: begin
					if (text_byte == stt_pkg::CH_STAR) begin
						mode_nx = stt_pkg::MODE_CMT;
					end else begin
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_EQ: begin
					if (comp_hit) begin
						b_vld = 1'b1;
						b_tok = '0;
						b_tok.kind = comp_k;
						b_tok.start = ps16;
						b_tok.length = 16'd2;
						mode_nx = stt_pkg::MODE_IDLE;
					end else begin
						do_start = 1'b1;
					end
				end
				stt_pkg::MODE_CMT, stt_pkg::MODE_CMTSTAR: begin
					if (text_byte == stt_pkg::CH_NUL) begin
						b_vld = 1'b1;
						b_tok = '0;
						b_tok.kind = stt_pkg::K_EOF;
						b_tok.start = p16;
						mode_nx = stt_pkg::MODE_IDLE;
					end else if (text_byte == stt_pkg::CH_STAR) begin
						mode_nx = stt_pkg::MODE_CMTSTAR;
					end else if (text_byte == stt_pkg::CH_SLASH &&
							mode == stt_pkg::MODE_CMTSTAR) begin
						mode_nx = stt_pkg::MODE_IDLE;
					end else begin
						mode_nx = stt_pkg::MODE_CMT;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase
			// Flush what was pending, then treat the byte as between tokens.
			if (do_start) begin
				a_vld = pend_vld;
				b_vld = st_emit;
				mode_nx = st_mode;
				if (st_begin) begin
					pstart_nx = pos;
					plen_nx = 16'd1;
					prefix_nx = {40'd0, text_byte};
				end
			end
			// Grow the pending word or number.
			if (do_extend) begin
				if (plen < 16'd6) begin
					prefix_nx = {prefix[39:0], text_byte};
				end
				if (plen != stt_pkg::LEN_MAX) begin
					plen_nx = plen + 1'b1;
				end
			end
		end
	end

	// Pack the tokens in order and mark the last one.
	always_comb begin
		res = '0;
		res.count = {1'b0, a_vld} + {1'b0, b_vld};
		res.tok0 = a_vld ? a_tok : b_tok;
		res.tok1 = b_tok;
		if (a_vld && b_vld) begin
			res.tok1.last = 1'b1;
		end else begin
			res.tok0.last = 1'b1;
		end
	end

endmodule

/* rtl/core/stt_outq.sv */
// Two-entry result queue that drives the token output channel.
// Depends on stt_pkg, stt_token_if and the assertion macro header.
`include "source_text_tokenizer_top_defines.svh"

module stt_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  stt_pkg::step_res_t res,
	output logic               room,
	stt_token_if.source        tokens
);

	logic [1:0]      cnt_q;
	stt_pkg::token_t slot0_q;
	stt_pkg::token_t slot1_q;
	logic            pop;
	logic            load;

	assign pop = tokens.valid && tokens.ready;
	assign load = push && res.count != 2'd0;

	// A new set may be loaded once the queue is empty after this cycle's beat.
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && tokens.ready);

	// Occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Token slots; the second one moves up after the head beat goes out.
	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res.tok0;
			slot1_q <= res.tok1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign tokens.valid = cnt_q != 2'd0;
	assign tokens.token_kind = slot0_q.kind;
	assign tokens.token_start = slot0_q.start;
	assign tokens.token_length = slot0_q.length;
	assign tokens.last_of_run = slot0_q.last;

	`STT_ASSERT_HOLD(a_load_room, clk, arst_n, load, room, "token set loaded without room")
	`STT_ASSERT_HOLD(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3, "queue count out of range")
	`STT_ASSERT_HOLD(a_pair_last, clk, arst_n, load && res.count == 2'd2,
		res.tok1.last && !res.tok0.last, "token pair marks wrong beat as last")
	`STT_ASSERT_NEXT(a_pair_held, clk, arst_n, load && res.count == 2'd2,
		cnt_q == 2'd2, "token pair not held in queue")

endmodule

/* rtl/core/source_text_tokenizer_top.sv */
// Top level of the source text tokenizer: input register, scanner state, step and queue.
// Depends on stt_pkg, stt_if, stt_step, stt_outq and the assertion macro header.
//
// Channel  Dir   Beat contents
// text     in    text_byte, end_of_text
// tokens   out   token_kind, token_start, token_length, last_of_run
//
// One byte is taken every cycle unless the input register holds a stalled byte. A byte is
// held in the input register, and its tokens pass through the result queue to the output.
// The two-entry result queue sets the pace: a byte that ends two tokens holds it for two
// beats, so the next byte that makes a token waits for room; bytes making no token pass.
// Reset returns the scanner to between tokens at offset zero and empties both registers.
// A stall on the token side holds the input register only when its byte makes a token.
`include "source_text_tokenizer_top_defines.svh"

module source_text_tokenizer_top #(
	parameter int POS_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	stt_text_if.sink  text,
	stt_token_if.source tokens
);

	logic                      in_valid_s1;
	logic [7:0]                in_byte_s1;
	logic                      in_end_s1;
	stt_pkg::mode_t            mode_q;
	logic [POS_WIDTH-1:0]      pos_q;
	logic [POS_WIDTH-1:0]      pstart_q;
	logic [stt_pkg::TOK_W-1:0] plen_q;
	logic [47:0]               prefix_q;
	stt_pkg::mode_t            mode_nx;
	logic [POS_WIDTH-1:0]      pos_nx;
	logic [POS_WIDTH-1:0]      pstart_nx;
	logic [stt_pkg::TOK_W-1:0] plen_nx;
	logic [47:0]               prefix_nx;
	stt_pkg::step_res_t        res;
	logic                      room;
	logic                      fire;
	logic                      take;

	// The registered byte is processed when its tokens fit in the queue.
	assign fire = in_valid_s1 && (res.count == 2'd0 || room);
	assign text.ready = !in_valid_s1 || fire;
	assign take = text.valid && text.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (take) begin
			in_valid_s1 <= 1'b1;
		end else if (fire) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			in_byte_s1 <= text.text_byte;
			in_end_s1 <= text.end_of_text;
		end
	end

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			pos_q <= '0;
			pstart_q <= '0;
			plen_q <= '0;
			prefix_q <= '0;
		end else if (fire) begin
			mode_q <= mode_nx;
			pos_q <= pos_nx;
			pstart_q <= pstart_nx;
			plen_q <= plen_nx;
			prefix_q <= prefix_nx;
		end
	end

	stt_step #(
		.POS_WIDTH(POS_WIDTH)
	) u_step (
		.mode(mode_q),
		.pos(pos_q),
		.pstart(pstart_q),
		.plen(plen_q),
		.prefix(prefix_q),
		.text_byte(in_byte_s1),
		.end_of_text(in_end_s1),
		.mode_nx(mode_nx),
		.pos_nx(pos_nx),
		.pstart_nx(pstart_nx),
		.plen_nx(plen_nx),
		.prefix_nx(prefix_nx),
		.res(res)
	);

	stt_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(fire),
		.res(res),
		.room(room),
		.tokens(tokens)
	);

	`STT_ASSERT_NEXT(a_halt_sticky, clk, arst_n, mode_q == stt_pkg::MODE_HALT,
		mode_q == stt_pkg::MODE_HALT, "scanner left the halted mode")
	`STT_ASSERT_HOLD(a_halt_quiet, clk, arst_n, mode_q == stt_pkg::MODE_HALT,
		res.count == 2'd0, "halted scanner produced a token")
	`STT_ASSERT_NEXT(a_byte_kept, clk, arst_n, in_valid_s1 && !fire,
		in_valid_s1 && $stable(in_byte_s1) && $stable(in_end_s1),
		"stalled byte lost from input register")

endmodule
